// ===== rtl/hsv_sweep_to_rgb_top_macros.svh =====
// ----------------------------------------------------------------------------
// hsv_sweep_to_rgb_top_macros: assertion shorthands
// Concurrent checks clocked on clk and held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef HSV_SWEEP_TO_RGB_TOP_MACROS_SVH
`define HSV_SWEEP_TO_RGB_TOP_MACROS_SVH

// Check cons in the same cycle as ante
`define HSV_S2R_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante
`define HSV_S2R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hsv_s2r_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv_s2r_pkg: shared types and constants
// Widths, scale factors, operation codes and sequencer control for the
// HSV sweep to RGB block.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv_s2r_pkg;

  localparam int HUE_W   = 9;
  localparam int PCT_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int STEP_W  = 6;
  localparam int MODE_W  = 2;
  localparam int MUL_A_W = 9;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [HUE_W-1:0]  HUE_TOP  = 9'd360;
  localparam logic [PCT_W-1:0]  PCT_TOP  = 7'd100;
  localparam logic [BYTE_W-1:0] SECTOR   = 8'd43;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

  // floor(v*255/360) == (v*HUE_RECIP) >> HUE_SHIFT for v in 0..360
  localparam logic [MUL_B_W-1:0] HUE_RECIP = 16'd46427;
  localparam int                 HUE_SHIFT = 16;
  // floor(v*255/100) == (v*PCT_RECIP) >> PCT_SHIFT for v in 0..100
  localparam logic [MUL_B_W-1:0] PCT_RECIP = 16'd41780;
  localparam int                 PCT_SHIFT = 14;
  localparam int                 FRAC_SHIFT = 8;

  typedef enum logic [2:0] {
    OP_HUE, OP_SAT, OP_BRI, OP_P, OP_X1, OP_X2, OP_Q, OP_T
  } mul_op_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} seq_state_t;

  typedef enum logic [1:0] {MODE_HOLD, MODE_HUE, MODE_SAT, MODE_BRI} sweep_mode_t;

  typedef enum logic {CFG_SWEEP_MODE, CFG_STEP_SIZE} cfg_index_t;

  typedef enum logic {CMD_TICK, CMD_LOAD} command_t;

  typedef struct packed {
    logic    start;
    logic    run;
    mul_op_t op;
    logic    last;
  } seq_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/hsv_s2r_mul.sv =====
// ----------------------------------------------------------------------------
// hsv_s2r_mul: shared multiply unit
// Selects the operands of one conversion step, multiplies them and returns
// the scaled 8-bit byte of the product.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_s2r_mul
  import hsv_s2r_pkg::*;
(
  input  mul_op_t           op,
  input  logic [HUE_W-1:0]  hue_level,
  input  logic [PCT_W-1:0]  saturation_level,
  input  logic [PCT_W-1:0]  brightness_level,
  input  logic [BYTE_W-1:0] sat_byte,
  input  logic [BYTE_W-1:0] val_byte,
  input  logic [BYTE_W-1:0] rem6,
  input  logic [BYTE_W-1:0] x1,
  input  logic [BYTE_W-1:0] x2,
  output logic [BYTE_W-1:0] result
);

  logic [MUL_A_W-1:0] op_a;
  logic [MUL_B_W-1:0] op_b;
  logic [MUL_P_W-1:0] prod;

  // Pick operands for the current step
  always_comb begin
    unique case (op)
      OP_HUE: begin
        op_a = hue_level;
        op_b = HUE_RECIP;
      end
      OP_SAT: begin
        op_a = MUL_A_W'(saturation_level);
        op_b = PCT_RECIP;
      end
      OP_BRI: begin
        op_a = MUL_A_W'(brightness_level);
        op_b = PCT_RECIP;
      end
      OP_P: begin
        op_a = MUL_A_W'(val_byte);
        op_b = MUL_B_W'(BYTE_MAX - sat_byte);
      end
      OP_X1: begin
        op_a = MUL_A_W'(sat_byte);
        op_b = MUL_B_W'(rem6);
      end
      OP_X2: begin
        op_a = MUL_A_W'(sat_byte);
        op_b = MUL_B_W'(BYTE_MAX - rem6);
      end
      OP_Q: begin
        op_a = MUL_A_W'(val_byte);
        op_b = MUL_B_W'(BYTE_MAX - x1);
      end
      OP_T: begin
        op_a = MUL_A_W'(val_byte);
        op_b = MUL_B_W'(BYTE_MAX - x2);
      end
    endcase
  end

  assign prod = MUL_P_W'(op_a) * MUL_P_W'(op_b);

  // Take the byte at the step's fixed-point position
  always_comb begin
    unique case (op) inside
      OP_HUE:         result = prod[HUE_SHIFT +: BYTE_W];
      OP_SAT, OP_BRI: result = prod[PCT_SHIFT +: BYTE_W];
      default:        result = prod[FRAC_SHIFT +: BYTE_W];
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/hsv_s2r_bounce.sv =====
// ----------------------------------------------------------------------------
// hsv_s2r_bounce: bouncing step unit
// Moves one swept level by the step size, turning around at 0 and at the
// channel maximum, and saturating a turn that would leave the range.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_s2r_bounce
  import hsv_s2r_pkg::*;
(
  input  logic [HUE_W-1:0]  level,
  input  logic [STEP_W-1:0] step,
  input  logic [HUE_W-1:0]  top,
  input  logic              down,
  output logic [HUE_W-1:0]  level_next,
  output logic              down_next
);

  logic [HUE_W-1:0] step_ext;
  logic [HUE_W:0]   sum;
  logic [HUE_W-1:0] diff;

  assign step_ext = HUE_W'(step);
  assign sum      = {1'b0, level} + {1'b0, step_ext};
  assign diff     = level - step_ext;

  // Advance or turn around
  always_comb begin
    if (down) begin
      if (level < step_ext) begin
        down_next  = 1'b0;
        level_next = (sum > {1'b0, top}) ? top : sum[HUE_W-1:0];
      end else begin
        down_next  = 1'b1;
        level_next = diff;
      end
    end else begin
      if (sum > {1'b0, top}) begin
        down_next  = 1'b1;
        level_next = (level >= step_ext) ? diff : '0;
      end else begin
        down_next  = 1'b0;
        level_next = sum[HUE_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hsv_s2r_seq.sv =====
// ----------------------------------------------------------------------------
// hsv_s2r_seq: step sequencer
// Takes one transaction, walks the multiply unit through its eight steps and
// holds the result until the output side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_s2r_seq
  import hsv_s2r_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_ready,
  output logic      in_ready,
  output logic      out_valid,
  output seq_ctrl_t ctrl
);

  seq_state_t state;
  seq_state_t state_next;
  logic [2:0] step;
  logic [2:0] step_next;

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state and step controls
  always_comb begin
    state_next = state;
    step_next  = step;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    ctrl.start = 1'b0;
    ctrl.run   = 1'b0;
    ctrl.op    = mul_op_t'(step);
    ctrl.last  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.start = 1'b1;
          step_next  = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        ctrl.run = 1'b1;
        if (ctrl.op == OP_T) begin
          ctrl.last  = 1'b1;
          state_next = ST_DONE;
        end else begin
          step_next = step + 3'd1;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/hsv_sweep_to_rgb_top.sv =====
// ----------------------------------------------------------------------------
// hsv_sweep_to_rgb_top: HSV holder with bouncing sweep and 8-bit RGB output
// The result is valid after the input transaction is taken and the sequencer
// has run eight passes through the single shared multiplier; no new
// transaction is taken until the result has been handed off.
// Reset: HSV levels zero, all sweep directions up, mode hold, step size 1.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsv_sweep_to_rgb_top_macros.svh"

module hsv_sweep_to_rgb_top
  import hsv_s2r_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [STEP_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [HUE_W-1:0]  hue_in,
  input  logic [PCT_W-1:0]  saturation_in,
  input  logic [PCT_W-1:0]  brightness_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] red,
  output logic [BYTE_W-1:0] green,
  output logic [BYTE_W-1:0] blue,
  output logic [HUE_W-1:0]  hue_out,
  output logic [PCT_W-1:0]  saturation_out,
  output logic [PCT_W-1:0]  brightness_out
);

  localparam int DIR_HUE = 0;
  localparam int DIR_SAT = 1;
  localparam int DIR_BRI = 2;

  seq_ctrl_t          ctrl;
  sweep_mode_t        sweep_mode;
  logic [STEP_W-1:0]  step_size;
  logic [HUE_W-1:0]   hue_level;
  logic [PCT_W-1:0]   saturation_level;
  logic [PCT_W-1:0]   brightness_level;
  logic [2:0]         dir_flags;
  logic               is_tick;

  logic               grey;
  logic [BYTE_W-1:0]  hue_byte;
  logic [BYTE_W-1:0]  sat_byte;
  logic [BYTE_W-1:0]  val_byte;
  logic [BYTE_W-1:0]  p_term;
  logic [BYTE_W-1:0]  q_term;
  logic [BYTE_W-1:0]  t_term;
  logic [BYTE_W-1:0]  x1;
  logic [BYTE_W-1:0]  x2;

  logic [BYTE_W-1:0]  mul_res;
  logic [2:0]         region;
  logic [BYTE_W-1:0]  region_base;
  logic [BYTE_W-1:0]  rem;
  logic [BYTE_W-1:0]  rem6;

  logic [HUE_W-1:0]   bnc_level;
  logic [HUE_W-1:0]   bnc_top;
  logic               bnc_down;
  logic [HUE_W-1:0]   bnc_level_next;
  logic               bnc_down_next;

  hsv_s2r_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  hsv_s2r_mul u_mul (
    .op               (ctrl.op),
    .hue_level        (hue_level),
    .saturation_level (saturation_level),
    .brightness_level (brightness_level),
    .sat_byte         (sat_byte),
    .val_byte         (val_byte),
    .rem6             (rem6),
    .x1               (x1),
    .x2               (x2),
    .result           (mul_res)
  );

  hsv_s2r_bounce u_bounce (
    .level      (bnc_level),
    .step       (step_size),
    .top        (bnc_top),
    .down       (bnc_down),
    .level_next (bnc_level_next),
    .down_next  (bnc_down_next)
  );

  // Hue region and remainder from the scaled hue
  always_comb begin
    region      = '0;
    region_base = '0;
    for (int k = 1; k < 6; k++) begin
      if (hue_byte >= BYTE_W'(k * SECTOR)) begin
        region      = 3'(k);
        region_base = BYTE_W'(k * SECTOR);
      end
    end
    rem  = hue_byte - region_base;
    rem6 = BYTE_W'({rem, 2'b00} + {1'b0, rem, 1'b0});
  end

  // Route the swept channel to the bounce unit
  always_comb begin
    unique case (sweep_mode)
      MODE_SAT: begin
        bnc_level = HUE_W'(saturation_level);
        bnc_top   = HUE_W'(PCT_TOP);
        bnc_down  = dir_flags[DIR_SAT];
      end
      MODE_BRI: begin
        bnc_level = HUE_W'(brightness_level);
        bnc_top   = HUE_W'(PCT_TOP);
        bnc_down  = dir_flags[DIR_BRI];
      end
      MODE_HUE, MODE_HOLD: begin
        bnc_level = hue_level;
        bnc_top   = HUE_TOP;
        bnc_down  = dir_flags[DIR_HUE];
      end
    endcase
  end

  // Configuration, held levels and sweep directions
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_mode       <= MODE_HOLD;
      step_size        <= STEP_W'(1);
      hue_level        <= '0;
      saturation_level <= '0;
      brightness_level <= '0;
      dir_flags        <= '0;
      is_tick          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_SWEEP_MODE: sweep_mode <= sweep_mode_t'(cfg_data[MODE_W-1:0]);
          CFG_STEP_SIZE:  step_size  <= cfg_data;
        endcase
      end
      // Load clamps the new values into range
      if (ctrl.start) begin
        is_tick <= (command_t'(command) == CMD_TICK);
        if (command_t'(command) == CMD_LOAD) begin
          hue_level        <= (hue_in > HUE_TOP) ? HUE_TOP : hue_in;
          saturation_level <= (saturation_in > PCT_TOP) ? PCT_TOP : saturation_in;
          brightness_level <= (brightness_in > PCT_TOP) ? PCT_TOP : brightness_in;
        end
      end
      // Sweep after the conversion has read the old levels
      if (ctrl.last && is_tick) begin
        case (sweep_mode)
          MODE_HUE: begin
            hue_level          <= bnc_level_next;
            dir_flags[DIR_HUE] <= bnc_down_next;
          end
          MODE_SAT: begin
            saturation_level   <= bnc_level_next[PCT_W-1:0];
            dir_flags[DIR_SAT] <= bnc_down_next;
          end
          MODE_BRI: begin
            brightness_level   <= bnc_level_next[PCT_W-1:0];
            dir_flags[DIR_BRI] <= bnc_down_next;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Capture each step's product
  always_ff @(posedge clk) begin
    if (ctrl.run) begin
      unique case (ctrl.op)
        OP_HUE: begin
          hue_byte <= mul_res;
          grey     <= (saturation_level == '0);
        end
        OP_SAT: sat_byte <= mul_res;
        OP_BRI: val_byte <= mul_res;
        OP_P:   p_term   <= mul_res;
        OP_X1:  x1       <= mul_res;
        OP_X2:  x2       <= mul_res;
        OP_Q:   q_term   <= mul_res;
        OP_T:   t_term   <= mul_res;
      endcase
    end
  end

  // Assemble RGB from the held terms
  always_comb begin
    if (grey) begin
      red   = val_byte;
      green = val_byte;
      blue  = val_byte;
    end else begin
      case (region)
        3'd0: begin
          red = val_byte; green = t_term; blue = p_term;
        end
        3'd1: begin
          red = q_term; green = val_byte; blue = p_term;
        end
        3'd2: begin
          red = p_term; green = val_byte; blue = t_term;
        end
        3'd3: begin
          red = p_term; green = q_term; blue = val_byte;
        end
        3'd4: begin
          red = t_term; green = p_term; blue = val_byte;
        end
        default: begin
          red = val_byte; green = p_term; blue = q_term;
        end
      endcase
    end
  end

  assign hue_out        = hue_level;
  assign saturation_out = saturation_level;
  assign brightness_out = brightness_level;

  // Checks
  `HSV_S2R_ASSERT_HOLDS(a_busy_excl, out_valid, !in_ready, "input taken while result pending")
  `HSV_S2R_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready && !out_valid, "sequencer skipped steps")
  `HSV_S2R_ASSERT_HOLDS(a_level_range, 1'b1, (hue_level <= HUE_TOP) && (saturation_level <= PCT_TOP) && (brightness_level <= PCT_TOP), "held level out of range")
  `HSV_S2R_ASSERT_HOLDS(a_grey_path, out_valid && grey, (red == green) && (green == blue), "grey result not uniform")

endmodule

`default_nettype wire
